// ===== rtl/core/ptd_pkg.sv =====
package ptd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ANGLE_W    = 16;
	localparam int OUT_W      = 18;
	localparam int FRAC_W     = 15;
	localparam int PROD_W     = 2 * SAMPLE_W;

	// quarter-wave table geometry
	localparam int SINE_N     = 1024;
	localparam int K_W        = $clog2(SINE_N);
	localparam int IDX_W      = K_W + 1;
	localparam int CHUNK      = 256;
	localparam int CHUNK_W    = $clog2(CHUNK);
	localparam int NUM_CHUNKS = SINE_N / CHUNK;
	localparam int SEL_W      = IDX_W - CHUNK_W;
	localparam int CSEL_W     = $clog2(NUM_CHUNKS);
	localparam int ENTRY_W    = 15;
	localparam int K_SHIFT    = ANGLE_W - 2 - K_W;

	// stream packing
	localparam int S_TDATA_W  = 4 * SAMPLE_W;
	localparam int M_FIELDS_W = 2 * OUT_W + SAMPLE_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// configuration codes
	localparam logic ALIGN_A_AXIS   = 1'b1;
	localparam logic ALIGN_90_BEHIND = 1'b0;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned HALF_Q30    = 64'd536870912;
	localparam longint unsigned AMPLITUDE   = 64'd32767;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    result_t;
	typedef logic [ANGLE_W-1:0]         angle_t;
	typedef logic [ENTRY_W-1:0]         entry_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// round(32767 * sin(pi/2 * k / N)) by a Q30 Taylor series, clamped
	function automatic entry_t sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned r;
		x    = (HALF_PI_Q30 * 64'(k)) / SINE_N;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 156;
		sum  = sum + term;
		r = (sum * AMPLITUDE + HALF_Q30) >> 30;
		if (r > AMPLITUDE) begin
			r = AMPLITUDE;
		end
		return r[ENTRY_W-1:0];
	endfunction

endpackage

// ===== rtl/core/park_transform_dq0_unit.sv =====
// Park transform, alpha/beta/zero to d/q/zero.
//
// Input stream (s_*): one item carries alpha, beta and zero-sequence samples
// in Q1.15 plus a rotor angle (65536 = one turn). Output stream (m_*): one
// item per input item, d and q in Q2.15 rounded half up, zero passed through.
// Configuration (cfg_*): one bit, 1 = d axis aligned to phase A, 0 = d axis
// 90 degrees behind A. cfg_ready is always high; write only while idle.
//
// Pipeline: s1 input register, s2 quarter-wave table read (four 256-entry
// chunks per index, chunk picked after the register), s3 four 16x16
// products, s4 sum, round and result register. An accepted item passes
// through s1, s2, s3 and s4 in order, and m_tvalid is the s4 valid.
// Throughput is one item per cycle while the receiver does not stall.
//
// When the receiver stalls, each stage holds only if the stage after it is
// full; empty stages keep filling, so up to four items sit in the block.
// Reset clears all stage valids and sets the alignment bit to A-axis.
module park_transform_dq0_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// alpha_in [15:0], beta_in [31:16], zero_seq_in [47:32], angle [63:48]
	input  logic [ptd_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// d_out [17:0], q_out [35:18], zero_out [51:36], zero pad [55:52]
	output logic [ptd_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);
	import ptd_pkg::*;

	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      align_q;
	sample_t   alpha_s1, beta_s1, zero_s1;
	sample_t   alpha_s2, beta_s2, zero_s2;
	sample_t   zero_s3, zero_s4;
	angle_t    angle_s1;
	sample_t   sin_s2, cos_s2;
	result_t   d_s4, q_s4;

	// a stage loads when it is empty or its content moves on
	assign en.s4 = !v_s4 || m_tready;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign s_tready  = en.s1;
	assign m_tvalid  = v_s4;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {{M_PAD_W{1'b0}}, zero_s4, q_s4, d_s4};

	// stage valids and the alignment register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			align_q <= ALIGN_A_AXIS;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (cfg_valid) align_q <= cfg_data;
		end
	end

	// sample payload; the angle goes to the table stage only
	always_ff @(posedge clk) begin
		if (en.s1) begin
			alpha_s1 <= s_tdata[SAMPLE_W-1:0];
			beta_s1  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			zero_s1  <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
			angle_s1 <= s_tdata[3*SAMPLE_W+ANGLE_W-1:3*SAMPLE_W];
		end
		if (en.s2) begin
			alpha_s2 <= alpha_s1;
			beta_s2  <= beta_s1;
			zero_s2  <= zero_s1;
		end
		if (en.s3) zero_s3 <= zero_s2;
		if (en.s4) zero_s4 <= zero_s3;
	end

	ptd_sincos u_sincos (
		.clk      (clk),
		.en       (en),
		.angle_s1 (angle_s1),
		.sin_s2   (sin_s2),
		.cos_s2   (cos_s2)
	);

	ptd_rotate u_rotate (
		.clk      (clk),
		.en       (en),
		.align    (align_q),
		.alpha_s2 (alpha_s2),
		.beta_s2  (beta_s2),
		.sin_s2   (sin_s2),
		.cos_s2   (cos_s2),
		.d_s4     (d_s4),
		.q_s4     (q_s4)
	);

endmodule

// ===== rtl/core/ptd_sincos.sv =====
module ptd_sincos (
	input  logic                clk,
	input  ptd_pkg::stage_en_t  en,
	input  ptd_pkg::angle_t     angle_s1,
	output ptd_pkg::sample_t    sin_s2,
	output ptd_pkg::sample_t    cos_s2
);
	import ptd_pkg::*;

	localparam entry_t TOP_ENTRY = sine_entry(SINE_N);

	entry_t            rom [NUM_CHUNKS][CHUNK];
	logic [K_W-1:0]    k;
	logic [IDX_W-1:0]  idx_p;
	logic [IDX_W-1:0]  idx_m;
	entry_t            rd_p_s2 [NUM_CHUNKS];
	entry_t            rd_m_s2 [NUM_CHUNKS];
	logic [SEL_W-1:0]  sel_p_s2;
	logic [SEL_W-1:0]  sel_m_s2;
	logic [1:0]        quad_s2;
	entry_t            t_p;
	entry_t            t_m;
	sample_t           pos_p;
	sample_t           pos_m;

	// constant quarter-wave table, split into chunks of CHUNK entries
	for (genvar c = 0; c < NUM_CHUNKS; c++) begin : g_chunk
		for (genvar e = 0; e < CHUNK; e++) begin : g_entry
			assign rom[c][e] = sine_entry(c * CHUNK + e);
		end
	end

	assign k     = K_W'(angle_s1[ANGLE_W-3:0] >> K_SHIFT);
	assign idx_p = {1'b0, k};
	assign idx_m = IDX_W'(SINE_N) - idx_p;

	// read every chunk at the low index bits, pick the chunk next cycle
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int c = 0; c < NUM_CHUNKS; c++) begin
				rd_p_s2[c] <= rom[c][idx_p[CHUNK_W-1:0]];
				rd_m_s2[c] <= rom[c][idx_m[CHUNK_W-1:0]];
			end
			sel_p_s2 <= idx_p[IDX_W-1:CHUNK_W];
			sel_m_s2 <= idx_m[IDX_W-1:CHUNK_W];
			quad_s2  <= angle_s1[ANGLE_W-1:ANGLE_W-2];
		end
	end

	assign t_p   = (sel_p_s2 == SEL_W'(NUM_CHUNKS)) ? TOP_ENTRY : rd_p_s2[sel_p_s2[CSEL_W-1:0]];
	assign t_m   = (sel_m_s2 == SEL_W'(NUM_CHUNKS)) ? TOP_ENTRY : rd_m_s2[sel_m_s2[CSEL_W-1:0]];
	assign pos_p = sample_t'({1'b0, t_p});
	assign pos_m = sample_t'({1'b0, t_m});

	// fold the quadrant into sign and table direction
	always_comb begin
		case (quad_s2)
			2'd0: begin
				sin_s2 = pos_p;
				cos_s2 = pos_m;
			end
			2'd1: begin
				sin_s2 = pos_m;
				cos_s2 = -pos_p;
			end
			2'd2: begin
				sin_s2 = -pos_p;
				cos_s2 = -pos_m;
			end
			2'd3: begin
				sin_s2 = -pos_m;
				cos_s2 = pos_p;
			end
			default: begin
				sin_s2 = pos_p;
				cos_s2 = pos_m;
			end
		endcase
	end

endmodule

// ===== rtl/core/ptd_rotate.sv =====
module ptd_rotate (
	input  logic                clk,
	input  ptd_pkg::stage_en_t  en,
	input  logic                align,
	input  ptd_pkg::sample_t    alpha_s2,
	input  ptd_pkg::sample_t    beta_s2,
	input  ptd_pkg::sample_t    sin_s2,
	input  ptd_pkg::sample_t    cos_s2,
	output ptd_pkg::result_t    d_s4,
	output ptd_pkg::result_t    q_s4
);
	import ptd_pkg::*;

	localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) <<< (FRAC_W - 1);

	logic signed [PROD_W-1:0] ac_s3;
	logic signed [PROD_W-1:0] as_s3;
	logic signed [PROD_W-1:0] bc_s3;
	logic signed [PROD_W-1:0] bs_s3;
	logic signed [PROD_W:0]   ac;
	logic signed [PROD_W:0]   as;
	logic signed [PROD_W:0]   bc;
	logic signed [PROD_W:0]   bs;
	logic signed [PROD_W:0]   d_sum;
	logic signed [PROD_W:0]   q_sum;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ac_s3 <= alpha_s2 * cos_s2;
			as_s3 <= alpha_s2 * sin_s2;
			bc_s3 <= beta_s2 * cos_s2;
			bs_s3 <= beta_s2 * sin_s2;
		end
	end

	assign ac = {ac_s3[PROD_W-1], ac_s3};
	assign as = {as_s3[PROD_W-1], as_s3};
	assign bc = {bc_s3[PROD_W-1], bc_s3};
	assign bs = {bs_s3[PROD_W-1], bs_s3};

	always_comb begin
		if (align == ALIGN_A_AXIS) begin
			d_sum = ac + bs + ROUND_HALF;
			q_sum = bc - as + ROUND_HALF;
		end else begin
			d_sum = as - bc + ROUND_HALF;
			q_sum = ac + bs + ROUND_HALF;
		end
	end

	// drop the low fraction bits: floor after adding half
	always_ff @(posedge clk) begin
		if (en.s4) begin
			d_s4 <= d_sum[PROD_W:FRAC_W];
			q_s4 <= q_sum[PROD_W:FRAC_W];
		end
	end

endmodule

// ===== rtl/core/ptd_checker.sv =====
module ptd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [ptd_pkg::S_TDATA_W-1:0]     s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ptd_pkg::M_TDATA_W-1:0]     m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic                              cfg_data
);
	import ptd_pkg::*;

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output means nothing blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with output empty");

	// with a free receiver an accepted item reaches the output, zero intact
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc ##1 m_tready ##1 m_tready ##1 m_tready |=>
			m_tvalid && (m_tdata[2*OUT_W+SAMPLE_W-1:2*OUT_W] ==
				$past(s_tdata[3*SAMPLE_W-1:2*SAMPLE_W], 4)))
		else $error("zero-sequence result late or wrong");

	// pad bits stay clear, configuration never blocks
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || (m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0)) &&
			(!cfg_valid || cfg_ready))
		else $error("pad bits set or config port blocked");

endmodule

bind park_transform_dq0_unit ptd_checker u_ptd_checker (.*);

// ===== test/dq0_result_checker.sv =====
module dq0_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// alpha_in [15:0], beta_in [31:16], zero_seq_in [47:32], angle [63:48]
	input  logic [ptd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// d_out [17:0], q_out [35:18], zero_out [51:36], zero pad [55:52]
	input  logic [ptd_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,
	output int                            mismatches,
	output int                            outstanding,
	output int                            results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// first member lands in the top bits: zero, then q, then d at the bottom
	typedef struct packed {
		ptd_pkg::sample_t z;
		ptd_pkg::result_t q;
		ptd_pkg::result_t d;
	} dq0_item_t;

	int        quarter_sine [0:ptd_pkg::SINE_N];
	dq0_item_t expected_dq0 [$];
	logic      align_now;
	int        fail_tally;
	int        result_tally;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
		fail_tally   = 0;
		result_tally = 0;
		for (int k = 0; k <= ptd_pkg::SINE_N; k++) begin
			quarter_sine[k] = series_sine(k);
		end
	end

	// Q30 Taylor series up to x^13, scaled to 32767 and clamped
	function automatic int series_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint          sum;
		x    = (ptd_pkg::HALF_PI_Q30 * 64'(k)) / ptd_pkg::SINE_N;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
			if (n % 2) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return int'(r);
	endfunction

	// fold the angle into a quadrant and a table index
	function automatic int sine_at(input ptd_pkg::angle_t ang);
		logic [1:0] quad;
		int         k;
		int         v;
		quad = ang[ptd_pkg::ANGLE_W-1 -: 2];
		k    = (int'(ang[ptd_pkg::ANGLE_W-3:0]) * ptd_pkg::SINE_N) >> (ptd_pkg::ANGLE_W - 2);
		if (k > ptd_pkg::SINE_N) begin
			k = ptd_pkg::SINE_N;
		end
		v = quad[0] ? quarter_sine[ptd_pkg::SINE_N - k] : quarter_sine[k];
		return quad[1] ? -v : v;
	endfunction

	// Q2.30 to Q2.15, half up
	function automatic ptd_pkg::result_t round_to_q15(input longint acc);
		longint r;
		r = (acc + 64'sd16384) >>> ptd_pkg::FRAC_W;
		return r[ptd_pkg::OUT_W-1:0];
	endfunction

	function automatic dq0_item_t predict_dq0(input logic [ptd_pkg::S_TDATA_W-1:0] word,
			input logic align);
		ptd_pkg::sample_t a;
		ptd_pkg::sample_t b;
		ptd_pkg::angle_t  ang;
		ptd_pkg::angle_t  cos_ang;
		longint           s;
		longint           c;
		longint           d;
		longint           q;
		dq0_item_t        e;
		a       = word[15:0];
		b       = word[31:16];
		ang     = word[63:48];
		cos_ang = ang + ptd_pkg::angle_t'(1 << (ptd_pkg::ANGLE_W - 2));
		s       = sine_at(ang);
		c       = sine_at(cos_ang);
		if (align == ptd_pkg::ALIGN_A_AXIS) begin
			d = a * c + b * s;
			q = b * c - a * s;
		end else begin
			d = a * s - b * c;
			q = a * c + b * s;
		end
		e.d = round_to_q15(d);
		e.q = round_to_q15(q);
		e.z = word[47:32];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dq0_item_t got;
		dq0_item_t want;
		if (!arst_n) begin
			expected_dq0.delete();
			align_now = ptd_pkg::ALIGN_A_AXIS;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[ptd_pkg::M_FIELDS_W-1:0];
				if (expected_dq0.size() == 0) begin
					$error("result item with nothing expected: d %0d q %0d zero %0d",
						got.d, got.q, got.z);
					fail_tally++;
				end else begin
					want = expected_dq0.pop_front();
					result_tally++;
					if (got.d !== want.d) begin
						$error("d_out mismatch: expected %0d, got %0d", want.d, got.d);
						fail_tally++;
					end
					if (got.q !== want.q) begin
						$error("q_out mismatch: expected %0d, got %0d", want.q, got.q);
						fail_tally++;
					end
					if (got.z !== want.z) begin
						$error("zero_out mismatch: expected %0d, got %0d", want.z, got.z);
						fail_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_dq0.push_back(predict_dq0(s_tdata, align_now));
			end
			if (cfg_valid && cfg_ready) begin
				align_now = cfg_data;
			end
		end
		mismatches   <= fail_tally;
		outstanding  <= expected_dq0.size();
		results_seen <= result_tally;
	end

endmodule

// ===== test/tb_park_transform_dq0_unit.sv =====
module tb_park_transform_dq0_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	// alpha_in [15:0], beta_in [31:16], zero_seq_in [47:32], angle [63:48]
	logic [ptd_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	// d_out [17:0], q_out [35:18], zero_out [51:36], zero pad [55:52]
	logic [ptd_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_data  = ptd_pkg::ALIGN_A_AXIS;

	int mismatches;
	int outstanding;
	int results_seen;
	int items_sent     = 0;
	// percent of cycles in which the sender holds off / the receiver stalls
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	always #4 clk = ~clk;

	park_transform_dq0_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dq0_result_checker u_dq0_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	// Receiver: redraw ready every cycle, so stalls land on every pipeline phase.
	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [ptd_pkg::S_TDATA_W-1:0] pack_item(input ptd_pkg::sample_t a,
			input ptd_pkg::sample_t b, input ptd_pkg::sample_t z, input ptd_pkg::angle_t ang);
		return {ang, z, b, a};
	endfunction

	// Mostly full-range values, with a share of the extremes, of zero and of minus one.
	function automatic ptd_pkg::sample_t pick_sample();
		ptd_pkg::sample_t v;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = '0;
				default: v = '1;
			endcase
		end else begin
			v = ptd_pkg::sample_t'($urandom);
		end
		return v;
	endfunction

	function automatic logic [ptd_pkg::S_TDATA_W-1:0] random_item();
		ptd_pkg::angle_t ang;
		// now and then sit on a quadrant boundary, one step either side
		if ($urandom_range(7) == 0) begin
			ang = ptd_pkg::angle_t'($urandom_range(3) * 16384 + $urandom_range(2) + 65535);
		end else begin
			ang = ptd_pkg::angle_t'($urandom);
		end
		return pack_item(pick_sample(), pick_sample(), pick_sample(), ang);
	endfunction

	// Offer one item, after a random hold-off; keep tvalid high until it is taken.
	task automatic send_item(input logic [ptd_pkg::S_TDATA_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drain the block, let the pipeline settle, then write the alignment bit.
	task automatic write_align(input logic value);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Field extremes, every quadrant boundary, wrap at the top of the turn,
	// and tiny inputs where rounding decides the sign.
	task automatic run_directed();
		send_item(pack_item(16'sh7fff, 16'sh0000, 16'sh0000, 16'd0));
		send_item(pack_item(16'sh8000, 16'sh8000, 16'sh8000, 16'd8192));
		send_item(pack_item(16'sh8000, 16'sh7fff, 16'sh7fff, 16'd57344));
		send_item(pack_item(16'sh7fff, 16'sh7fff, 16'shffff, 16'd16384));
		send_item(pack_item(16'sh7fff, 16'sh8000, 16'sh0001, 16'd32768));
		send_item(pack_item(16'sh8000, 16'sh7fff, 16'sh0000, 16'd49152));
		send_item(pack_item(16'sh0001, 16'sh0001, 16'sh0000, 16'd0));
		send_item(pack_item(16'shffff, 16'shffff, 16'sh0000, 16'd0));
		send_item(pack_item(16'sd12345, -16'sd23456, 16'sd777, 16'd65535));
		send_item(pack_item(-16'sd20000, 16'sd30000, -16'sd12345, 16'd16383));
		send_item(pack_item(16'sd30000, -16'sd30000, 16'sd100, 16'd32767));
		send_item(pack_item(16'sh0000, 16'sh0000, 16'sh0000, 16'd1));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed set under the reset alignment, then the other one
		run_directed();
		write_align(ptd_pkg::ALIGN_90_BEHIND);
		run_directed();

		// random phases: alternate the alignment, vary the idling pattern
		for (int phase = 0; phase < 5; phase++) begin
			write_align((phase % 2 == 0) ? ptd_pkg::ALIGN_A_AXIS : ptd_pkg::ALIGN_90_BEHIND);
			case (phase)
				1: begin
					send_idle_pct  = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 87;
				end
				3: begin
					send_idle_pct  = 15;
					recv_stall_pct = 15;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (165) send_item(random_item());
		end
		s_tvalid <= 1'b0;

		// wait out every expected result, then the pipeline depth
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d items under both d-axis alignments: directed extremes, then random",
			items_sent);
		$display("with idle input, stalled output and both; %0d results checked.", results_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_park_transform_dq0_unit passed");
		end else begin
			$display("tb_park_transform_dq0_unit failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("tb_park_transform_dq0_unit failed");
		$finish;
	end

endmodule
